### src/ptt_pkg.sv
// Shared types, request codes and constants of the timer table.
package ptt_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned ID_SPACE       = 16;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned SCALE_W  = 10;
  localparam int unsigned SPAN_W   = PERIOD_W + SCALE_W;

  localparam logic [SCALE_W-1:0] MS_TO_US = SCALE_W'(1000);

  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     slot_id;
    logic [PERIOD_W-1:0] period_ms;
    logic                fire_once;
    logic [TIME_W-1:0]   now_us;
  } ptt_req_t;

  typedef struct packed {
    logic            status;
    logic            fired;
    logic [ID_W-1:0] result_id;
    logic            last;
  } ptt_res_t;

  typedef struct packed {
    logic                fire_once;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   deadline;
  } ptt_slot_t;

endpackage

### src/ptt_if.sv
// Request and result channel interfaces of the timer table.
interface ptt_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::REQ_W-1:0]     req_type;
  logic [ptt_pkg::ID_W-1:0]      slot_id;
  logic [ptt_pkg::PERIOD_W-1:0]  period_ms;
  logic                          fire_once;
  logic [ptt_pkg::TIME_W-1:0]    now_us;

  modport source (output valid, req_type, slot_id, period_ms, fire_once, now_us,
                  input ready);
  modport sink   (input valid, req_type, slot_id, period_ms, fire_once, now_us,
                  output ready);
endinterface

interface ptt_res_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      fired;
  logic [ptt_pkg::ID_W-1:0]  result_id;
  logic                      last;

  modport source (output valid, status, fired, result_id, last, input ready);
  modport sink   (input valid, status, fired, result_id, last, output ready);
endinterface

### src/ptt_mem.sv
// Slot store: one-shot flag, period and deadline, one write and one registered read port.
module ptt_mem #(
  parameter int unsigned DEPTH = ptt_pkg::NUM_TIMERS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  ptt_pkg::ptt_slot_t                         wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output ptt_pkg::ptt_slot_t                         rdata_o
);
  import ptt_pkg::*;

  ptt_slot_t mem_q [DEPTH];
  ptt_slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ptt_calc.sv
// Shared deadline unit: registered period scaling, saturating add, expiry compare.
module ptt_calc (
  input  logic                          clk_i,
  input  logic                          mul_en_i,
  input  logic [ptt_pkg::PERIOD_W-1:0]  period_i,
  input  logic [ptt_pkg::TIME_W-1:0]    now_i,
  input  logic [ptt_pkg::TIME_W-1:0]    deadline_i,
  output logic [ptt_pkg::TIME_W-1:0]    sum_o,
  output logic                          reached_o
);
  import ptt_pkg::*;

  logic [SPAN_W-1:0]   span_q;
  logic [TIME_W:0]     sum_full;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      span_q <= SPAN_W'(period_i) * SPAN_W'(MS_TO_US);
    end
  end

  // saturate on carry out
  assign sum_full  = {1'b0, now_i} + (TIME_W + 1)'(span_q);
  assign sum_o     = sum_full[TIME_W] ? {TIME_W{1'b1}} : sum_full[TIME_W-1:0];
  assign reached_o = (now_i >= deadline_i);

endmodule

### src/periodic_one_shot_timer_table_unit.sv
// Top level of the timer table: request sequencer, slot flags and result register.
//
// Use: requests enter on req_i (valid/ready), results leave on res_o (valid/ready).
// Each request is one item carrying the current time in microseconds. The block
// takes one request at a time; req_i.ready is high only while the sequencer idles.
// Create, delete, stop and undefined codes each give one result.
// Start gives one result; for a known slot it first scales the period in
// the shared multiplier, then adds it to the time and writes the deadline.
// A tick walks the slots one at a time through the single slot-store read port
// and the shared deadline unit, and yields one result per expired slot, in
// ascending id order, or one quiet result.
// Results sit in an output register; a stalled receiver holds the sequencer
// at the step that needs to hand over the next result, nothing is dropped.
// Reset clears the slot valid and armed flags and the control state; the slot
// store needs no clearing pass, since a tick uses only entries of armed slots
// and start writes the entry as it arms it. After reset the block is ready at once.
module periodic_one_shot_timer_table_unit #(
  parameter int unsigned NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptt_req_if.sink    req_i,
  ptt_res_if.source  res_o
);
  import ptt_pkg::*;

  localparam int unsigned N  = (NUM_TIMERS < ID_SPACE) ? NUM_TIMERS : ID_SPACE;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;

  logic [2:0]    state_q, state_d;
  ptt_req_t      req_q;
  logic [N-1:0]  valid_q, valid_d;
  logic [N-1:0]  armed_q, armed_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] pend_id_q, pend_id_d;
  logic          pend_q, pend_d;
  logic          fire_q, fire_d;

  ptt_res_t      out_q;
  logic          out_valid_q;
  logic          out_free;
  logic          push;
  ptt_res_t      push_res;

  logic          accept;
  logic [IW-1:0] id_idx;
  logic          known;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic          mul_en;
  logic          sel_req;
  logic [TIME_W-1:0] sum;
  logic          reached;

  logic          mem_we;
  logic          mem_re;
  logic [IW-1:0] mem_waddr;
  ptt_slot_t     mem_wdata;
  ptt_slot_t     mem_rdata;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign id_idx = req_q.slot_id[IW-1:0];
  assign known  = ({1'b0, req_q.slot_id} < (ID_W + 1)'(N)) && valid_q[id_idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  ptt_calc u_calc (
    .clk_i      (clk_i),
    .mul_en_i   (mul_en),
    .period_i   (sel_req ? req_q.period_ms : mem_rdata.period),
    .now_i      (req_q.now_us),
    .deadline_i (mem_rdata.deadline),
    .sum_o      (sum),
    .reached_o  (reached)
  );

  ptt_mem #(.DEPTH(N)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    armed_d   = armed_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    fire_d    = fire_q;
    push      = 1'b0;
    push_res  = '{status: 1'b0, fired: 1'b0, result_id: '0, last: 1'b1};
    mul_en    = 1'b0;
    sel_req   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '{fire_once: mem_rdata.fire_once, period: mem_rdata.period, deadline: sum};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_q.req_type)
          REQ_CREATE: begin
            if (out_free) begin
              push               = 1'b1;
              push_res.status    = !free_found;
              push_res.result_id = free_found ? ID_W'(free_idx) : '0;
              if (free_found) begin
                valid_d[free_idx] = 1'b1;
                armed_d[free_idx] = 1'b0;
              end
              state_d = S_IDLE;
            end
          end
          REQ_DELETE, REQ_STOP: begin
            if (out_free) begin
              push            = 1'b1;
              push_res.status = !known;
              if (known) begin
                armed_d[id_idx] = 1'b0;
                if (req_q.req_type == REQ_DELETE) begin
                  valid_d[id_idx] = 1'b0;
                end
              end
              state_d = S_IDLE;
            end
          end
          REQ_START: begin
            if (known) begin
              mul_en  = 1'b1;
              sel_req = 1'b1;
              state_d = S_ADD;
            end else if (out_free) begin
              push            = 1'b1;
              push_res.status = 1'b1;
              state_d         = S_IDLE;
            end
          end
          REQ_TICK: begin
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = S_RD;
          end
          default: begin
            if (out_free) begin
              push            = 1'b1;
              push_res.status = 1'b1;
              state_d         = S_IDLE;
            end
          end
        endcase
      end
      S_ADD: begin
        if (out_free) begin
          mem_we          = 1'b1;
          mem_waddr       = id_idx;
          mem_wdata       = '{fire_once: req_q.fire_once, period: req_q.period_ms,
                              deadline: sum};
          armed_d[id_idx] = 1'b1;
          push            = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        mul_en  = 1'b1;
        fire_d  = valid_q[idx_q] && armed_q[idx_q] && reached;
        state_d = S_UPD;
      end
      S_UPD: begin
        // hold while an earlier fired item still needs the output register
        if (!fire_q || !pend_q || out_free) begin
          if (fire_q) begin
            if (pend_q) begin
              push     = 1'b1;
              push_res = '{status: 1'b0, fired: 1'b1, result_id: ID_W'(pend_id_q),
                           last: 1'b0};
            end
            if (mem_rdata.fire_once) begin
              armed_d[idx_q] = 1'b0;
            end else begin
              mem_we = 1'b1;
            end
            pend_d    = 1'b1;
            pend_id_d = idx_q;
          end
          if (idx_q == IW'(N - 1)) begin
            state_d = S_END;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_q) begin
            push_res = '{status: 1'b0, fired: 1'b1, result_id: ID_W'(pend_id_q),
                         last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      armed_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      armed_q     <= armed_d;
      pend_q      <= pend_d;
      out_valid_q <= push || (out_valid_q && !res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pend_id_q <= pend_id_d;
    fire_q    <= fire_d;
    if (accept) begin
      req_q <= '{req_type: req_i.req_type, slot_id: req_i.slot_id,
                 period_ms: req_i.period_ms, fire_once: req_i.fire_once,
                 now_us: req_i.now_us};
    end
    if (push) begin
      out_q <= push_res;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.status    = out_q.status;
  assign res_o.fired     = out_q.fired;
  assign res_o.result_id = out_q.result_id;
  assign res_o.last      = out_q.last;

endmodule

### src/ptt_chk.sv
// Port checker of the timer table and its bind to the top level.
module ptt_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      status_i,
  input logic                      fired_i,
  input logic [ptt_pkg::ID_W-1:0]  result_id_i,
  input logic                      last_i
);
  import ptt_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(status_i) && $stable(fired_i) &&
      $stable(result_id_i) && $stable(last_i))
    else $error("stalled result item changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after an accepted item");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fired_i |-> !status_i)
    else $error("fired item carries an error status");

  // only fired items of a tick may be followed by more
  a_more_only_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> fired_i)
    else $error("non-final item that is not a fired timer");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> last_i && (result_id_i == '0))
    else $error("error item with id or without last");

endmodule

bind periodic_one_shot_timer_table_unit ptt_chk u_ptt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .fired_i     (res_o.fired),
  .result_id_i (res_o.result_id),
  .last_i      (res_o.last)
);

### verif/ptt_table_checker.sv
// Timer table checker: predicts the results of every accepted request and compares them.
module ptt_table_checker
  import ptt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptt_req_if          req_i,
  ptt_res_if          res_i,
  output int unsigned fail_cnt_o,
  output int unsigned owed_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = (NUM_TIMERS < ID_SPACE) ? NUM_TIMERS : ID_SPACE;
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  logic                taken    [ID_SPACE];
  logic                running  [ID_SPACE];
  logic                single   [ID_SPACE];
  logic [PERIOD_W-1:0] period_tbl [ID_SPACE];
  logic [TIME_W-1:0]   expiry   [ID_SPACE];

  ptt_res_t    owed_results[$];
  int unsigned mismatches;

  assign fail_cnt_o = mismatches;

  // Saturating now + period * 1000.
  function automatic logic [TIME_W-1:0] expiry_after(input logic [TIME_W-1:0] now_us,
                                                     input logic [PERIOD_W-1:0] ms);
    logic [TIME_W:0] span;
    logic [TIME_W:0] sum;
    span = ms;
    span = span * MS_TO_US;
    sum  = {1'b0, now_us} + span;
    return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  task automatic owe(input logic status, input logic fired, input int unsigned id,
                     input logic last);
    ptt_res_t r;
    r.status    = status;
    r.fired     = fired;
    r.result_id = ID_W'(id);
    r.last      = last;
    owed_results.push_back(r);
  endtask

  task automatic apply_request(input ptt_req_t rq);
    logic        known;
    logic        claimed;
    int unsigned hits;
    known   = (rq.slot_id < SLOTS) && taken[rq.slot_id];
    claimed = 1'b0;
    hits    = 0;
    case (rq.req_type)
      REQ_CREATE: begin
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (!claimed && !taken[s]) begin
            claimed       = 1'b1;
            taken[s]      = 1'b1;
            running[s]    = 1'b0;
            single[s]     = 1'b0;
            period_tbl[s] = '0;
            expiry[s]     = '0;
            owe(ST_OK, 1'b0, s, 1'b1);
          end
        end
        if (!claimed) owe(ST_FAIL, 1'b0, 0, 1'b1);
      end
      REQ_DELETE: begin
        if (known) begin
          taken[rq.slot_id]   = 1'b0;
          running[rq.slot_id] = 1'b0;
        end
        owe(known ? ST_OK : ST_FAIL, 1'b0, 0, 1'b1);
      end
      REQ_START: begin
        if (known) begin
          period_tbl[rq.slot_id] = rq.period_ms;
          single[rq.slot_id]     = rq.fire_once;
          running[rq.slot_id]    = 1'b1;
          expiry[rq.slot_id]     = expiry_after(rq.now_us, rq.period_ms);
        end
        owe(known ? ST_OK : ST_FAIL, 1'b0, 0, 1'b1);
      end
      REQ_STOP: begin
        if (known) running[rq.slot_id] = 1'b0;
        owe(known ? ST_OK : ST_FAIL, 1'b0, 0, 1'b1);
      end
      REQ_TICK: begin
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (taken[s] && running[s] && rq.now_us >= expiry[s]) begin
            owe(ST_OK, 1'b1, s, 1'b0);
            hits++;
            if (single[s]) running[s] = 1'b0;
            else expiry[s] = expiry_after(rq.now_us, period_tbl[s]);
          end
        end
        if (hits == 0) owe(ST_OK, 1'b0, 0, 1'b1);
        else owed_results[owed_results.size()-1].last = 1'b1;
      end
      default: owe(ST_FAIL, 1'b0, 0, 1'b1);
    endcase
  endtask

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    $display("%0t: result %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ptt_req_t rq;
    ptt_res_t want;
    if (!rst_ni) begin
      for (int unsigned s = 0; s < ID_SPACE; s++) begin
        taken[s]   = 1'b0;
        running[s] = 1'b0;
      end
      owed_results.delete();
      mismatches = 0;
      owed_cnt_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (owed_results.size() == 0) begin
          $display({"%0t: unexpected result, expected none, ",
                    "actual status %0d fired %0d id %0d last %0d"},
                   $time, res_i.status, res_i.fired, res_i.result_id, res_i.last);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (res_i.status !== want.status) flag_field("status", want.status, res_i.status);
          if (res_i.fired !== want.fired) flag_field("fired", want.fired, res_i.fired);
          if (res_i.result_id !== want.result_id)
            flag_field("result_id", want.result_id, res_i.result_id);
          if (res_i.last !== want.last) flag_field("last", want.last, res_i.last);
        end
      end
      // The block holds one request at a time, so a result here never belongs to a new request.
      if (req_i.valid && req_i.ready) begin
        rq.req_type  = req_i.req_type;
        rq.slot_id   = req_i.slot_id;
        rq.period_ms = req_i.period_ms;
        rq.fire_once = req_i.fire_once;
        rq.now_us    = req_i.now_us;
        apply_request(rq);
      end
      owed_cnt_o <= owed_results.size();
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top of the timer table: clock, reset, request stimulus, result stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNDEF_FIRST = REQ_TICK + 3'd1;
  localparam logic [REQ_W-1:0] REQ_UNDEF_LAST  = '1;
  localparam int unsigned ITEMS_PER_PHASE = 148;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;

  logic clk_i;
  logic rst_ni;

  ptt_req_if req_if ();
  ptt_res_if res_if ();

  int unsigned fail_cnt;
  int unsigned owed_cnt;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned quiet_cycles;
  logic        hold_ask;
  logic [TIME_W-1:0] clock_us;

  periodic_one_shot_timer_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  ptt_table_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_i      (res_if),
    .fail_cnt_o (fail_cnt),
    .owed_cnt_o (owed_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request, idling at random first, and hold it until accepted.
  task automatic offer(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                       input logic [PERIOD_W-1:0] ms, input logic once,
                       input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.slot_id   <= id;
    req_if.period_ms <= ms;
    req_if.fire_once <= once;
    req_if.now_us    <= stamp;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed_cnt != 0);
  endtask

  task automatic random_request();
    int unsigned       pick;
    logic [REQ_W-1:0]  kind;
    logic [ID_W-1:0]   id;
    logic [PERIOD_W-1:0] ms;
    logic              once;
    logic [TIME_W-1:0] stamp;
    pick     = $urandom_range(99);
    clock_us = clock_us + $urandom_range(0, 2500);
    stamp    = clock_us;
    id       = ID_W'($urandom_range(15));
    ms       = $urandom_range(0, 4);
    once     = 1'($urandom_range(1));
    if (pick < 14) kind = REQ_CREATE;
    else if (pick < 24) kind = REQ_DELETE;
    else if (pick < 54) kind = REQ_START;
    else if (pick < 62) kind = REQ_STOP;
    else if (pick < 97) kind = REQ_TICK;
    else kind = REQ_W'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
    // now and then use full-width values, outside the running time base
    if ($urandom_range(99) < 4) begin
      ms    = $urandom;
      stamp = {$urandom, $urandom};
    end
    offer(kind, id, ms, once, stamp);
  endtask

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin
    logic held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ask && !held) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_TICK;
    req_if.slot_id   <= '0;
    req_if.period_ms <= '0;
    req_if.fire_once <= 1'b0;
    req_if.now_us    <= '0;
    hold_ask    = 1'b0;
    clock_us    = '0;
    tx_idle_pct = 35;
    rx_idle_pct = 59;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // quiet tick, commands on slots that do not exist and undefined codes
    offer(REQ_TICK, '0, '0, 1'b0, '0);
    offer(REQ_DELETE, 4'd0, '0, 1'b0, 64'd10);
    offer(REQ_START, 4'd9, 32'd3, 1'b1, 64'd20);
    offer(REQ_STOP, 4'd15, '0, 1'b0, 64'd30);
    offer(REQ_UNDEF_FIRST, 4'd5, '1, 1'b1, 64'd40);
    offer(REQ_UNDEF_LAST, 4'd10, '0, 1'b0, 64'd50);
    // fill the table, then one create too many
    for (int unsigned n = 0; n <= ID_SPACE; n++) offer(REQ_CREATE, ID_W'(n), '0, 1'b0, 64'd60);
    // deadline saturates; the tick at the top of the time range fires it
    offer(REQ_START, 4'd15, '1, 1'b1, '1 - 64'd5);
    offer(REQ_TICK, '0, '0, 1'b0, '1);
    drain();

    for (int unsigned phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 59 : 0;
      rx_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 35 : 0;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // back up the block behind a stalled receiver
        if (phase == 2 && n == 40) hold_ask = 1'b1;
        random_request();
        if (n == ITEMS_PER_PHASE / 2) drain();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
